[rtl/srl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_pkg - shared types and constants of the sampled rank lookup
// Array geometry, derived widths, request and result layouts, codes.
// ----------------------------------------------------------------------------
package srl_pkg;

    // Array geometry
    localparam int ENTRIES_PER_ARRAY = 4096;
    localparam int ROW_STRIDE        = 39;
    localparam int NUM_TABLES        = 2;
    localparam int NUM_STATS         = 10;
    localparam int NUM_ARRAYS        = NUM_TABLES * NUM_STATS;
    localparam int STORE_DEPTH       = NUM_ARRAYS * ENTRIES_PER_ARRAY;

    // Derived widths
    localparam int IDX_W  = (ENTRIES_PER_ARRAY > 1) ? $clog2(ENTRIES_PER_ARRAY) : 1;
    localparam int LEN_W  = $clog2(ENTRIES_PER_ARRAY + 1);
    localparam int ARR_W  = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SPAN_W = $clog2(ENTRIES_PER_ARRAY * ROW_STRIDE + 1);
    localparam int STEP_W = $clog2(IDX_W + 1);

    // Field widths of the request and result
    localparam int KIND_W      = 2;
    localparam int TSEL_W      = 1;
    localparam int SSEL_W      = 4;
    localparam int EIDX_W      = 12;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int ROW_W       = 18;
    localparam int CFG_INDEX_W = 1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POSITION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAGE     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNAVAIL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_FAR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_AVAILABLE_MASK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTDATED_MASK  = 1'd1;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [TSEL_W-1:0]         table_sel;
        logic [SSEL_W-1:0]         stat_sel;
        logic [EIDX_W-1:0]         entry_index;
        logic signed [VALUE_W-1:0] entry_value;
        logic signed [VALUE_W-1:0] query_value;
    } srl_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [ROW_W-1:0]          row_position;
        logic signed [VALUE_W-1:0] found_value;
        logic                      is_outdated;
    } srl_out_t;

    typedef struct packed {
        logic [NUM_TABLES-1:0] available_mask;
        logic [NUM_TABLES-1:0] outdated_mask;
    } srl_cfg_t;

endpackage

[rtl/srl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_ram - generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module srl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/srl_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_engine - request sequencer of the sampled rank lookup
// Writes loads, keeps array lengths, runs the binary search and page divide.
// ----------------------------------------------------------------------------
module srl_engine
    import srl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  srl_in_t            req,
    input  srl_cfg_t           cfg,
    output logic               res_valid,
    input  logic               res_ready,
    output srl_out_t           res,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [VALUE_W-1:0] ram_wdata,
    output logic               ram_re,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [VALUE_W-1:0] ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_DIVIDE = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_LATCH  = 3'd5;
    localparam logic [2:0] S_REPLY  = 3'd6;

    function automatic logic sel_valid(input logic [TSEL_W-1:0] tsel,
                                       input logic [SSEL_W-1:0] ssel);
        return (32'(tsel) < NUM_TABLES) && (32'(ssel) < NUM_STATS);
    endfunction

    function automatic logic [ARR_W-1:0] arr_of(input logic [TSEL_W-1:0] tsel,
                                                input logic [SSEL_W-1:0] ssel);
        return ARR_W'(32'(tsel) * NUM_STATS + 32'(ssel));
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [LEN_W-1:0]   len_reg [NUM_ARRAYS];
    srl_in_t            q_reg;
    srl_out_t           res_reg;
    logic               od_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [LEN_W-1:0]   lo_reg;
    logic [LEN_W-1:0]   hip_reg;
    logic [IDX_W-1:0]   mid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [SPAN_W-1:0]  rem_reg;
    logic [SPAN_W-1:0]  div_reg;
    logic [STEP_W-1:0]  step_reg;

    // Load path
    logic               accept;
    logic [ARR_W-1:0]   in_arr;
    logic               load_ok;

    // Setup decode
    logic               q_sel_ok;
    logic [ARR_W-1:0]   q_arr;
    logic [LEN_W-1:0]   q_len;
    logic [NUM_TABLES-1:0] avail_bits;
    logic [NUM_TABLES-1:0] od_bits;
    logic               q_avail;
    logic [31:0]        start;
    logic [31:0]        limit;
    logic               too_far;
    logic [ADDR_W-1:0]  base;
    logic [IDX_W-1:0]   mid_first;

    // Search step
    logic [LEN_W-1:0]   mid_ext;
    logic [LEN_W-1:0]   lo_g;
    logic [LEN_W:0]     sum_g;
    logic [LEN_W:0]     sum_l;
    logic [IDX_W-1:0]   mid_g;
    logic [IDX_W-1:0]   mid_l;
    logic               greater;
    logic               equal;
    logic               go_g;
    logic               go_l;
    logic               go_on;
    logic [LEN_W-1:0]   hip_end;
    logic [IDX_W-1:0]   idx_end;

    // Divide step
    logic               rem_ge;
    logic [IDX_W-1:0]   quo_new;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_arr    = arr_of(req.table_sel, req.stat_sel);
    assign load_ok   = accept && (req.kind == KIND_LOAD)
                       && sel_valid(req.table_sel, req.stat_sel)
                       && (32'(req.entry_index) < ENTRIES_PER_ARRAY);

    assign ram_we    = load_ok;
    assign ram_waddr = ADDR_W'(32'(in_arr) * ENTRIES_PER_ARRAY + 32'(req.entry_index));
    assign ram_wdata = req.entry_value;

    assign q_sel_ok   = sel_valid(q_reg.table_sel, q_reg.stat_sel);
    assign q_arr      = arr_of(q_reg.table_sel, q_reg.stat_sel);
    assign q_len      = q_sel_ok ? len_reg[q_arr] : '0;
    assign avail_bits = cfg.available_mask >> q_reg.table_sel;
    assign od_bits    = cfg.outdated_mask >> q_reg.table_sel;
    assign q_avail    = q_sel_ok && avail_bits[0];
    assign start      = q_reg.query_value[VALUE_W-1] ? 32'd0 : 32'(q_reg.query_value);
    assign limit      = 32'(q_len) * ROW_STRIDE;
    assign too_far    = (start >= limit);
    assign base       = ADDR_W'(32'(q_arr) * ENTRIES_PER_ARRAY);
    assign mid_first  = IDX_W'((q_len - LEN_W'(1)) >> 1);

    // Both successor probes are prepared from registers; the compare picks one.
    assign mid_ext = LEN_W'(mid_reg);
    assign lo_g    = mid_ext + LEN_W'(1);
    assign sum_g   = (LEN_W + 1)'(mid_ext) + (LEN_W + 1)'(hip_reg);
    assign sum_l   = (LEN_W + 1)'(lo_reg) + (LEN_W + 1)'(mid_ext) - (LEN_W + 1)'(1);
    assign mid_g   = IDX_W'(sum_g >> 1);
    assign mid_l   = IDX_W'(sum_l >> 1);
    assign greater = $signed(ram_rdata) > q_reg.query_value;
    assign equal   = $signed(ram_rdata) == q_reg.query_value;
    assign go_g    = lo_g < hip_reg;
    assign go_l    = lo_reg < mid_ext;
    assign go_on   = !equal && (greater ? go_g : go_l);
    assign hip_end = greater ? hip_reg : mid_ext;
    assign idx_end = (hip_end == '0) ? '0 : IDX_W'(hip_end - LEN_W'(1));

    assign rem_ge  = (rem_reg >= div_reg);
    assign quo_new = IDX_W'({idx_reg, rem_ge});

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = base_reg + ADDR_W'(idx_reg);
        case (state_reg)
            S_SETUP: begin
                ram_re    = q_avail && (q_reg.kind == KIND_POSITION) && (q_len != '0);
                ram_raddr = base + ADDR_W'(mid_first);
            end
            S_SEARCH: begin
                ram_re    = go_on;
                ram_raddr = base_reg + ADDR_W'(greater ? mid_g : mid_l);
            end
            S_FETCH: begin
                ram_re    = 1'b1;
            end
            default: begin
                ram_re    = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (req.kind == KIND_POSITION || req.kind == KIND_PAGE)) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                if (!q_avail) begin
                    state_next = S_REPLY;
                end else if (q_reg.kind == KIND_POSITION) begin
                    state_next = (q_len == '0) ? S_REPLY : S_SEARCH;
                end else begin
                    state_next = too_far ? S_REPLY : S_DIVIDE;
                end
            end
            S_SEARCH: begin
                if (equal) begin
                    state_next = S_LATCH;
                end else if (!go_on) begin
                    state_next = S_FETCH;
                end
            end
            S_DIVIDE: begin
                if (step_reg == '0) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_LATCH;
            end
            S_LATCH: begin
                state_next = S_REPLY;
            end
            S_REPLY: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_ARRAYS; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_ok) begin
                len_reg[in_arr] <= LEN_W'(32'(req.entry_index) + 32'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    q_reg <= req;
                end
            end
            S_SETUP: begin
                od_reg   <= od_bits[0];
                base_reg <= base;
                lo_reg   <= '0;
                hip_reg  <= q_len;
                mid_reg  <= mid_first;
                rem_reg  <= SPAN_W'(start);
                div_reg  <= SPAN_W'(32'(ROW_STRIDE) << (IDX_W - 1));
                step_reg <= STEP_W'(IDX_W - 1);
                idx_reg  <= '0;
                res_reg  <= '0;
                if (!q_avail) begin
                    res_reg.status <= ST_UNAVAIL;
                end else if (q_reg.kind == KIND_POSITION) begin
                    res_reg.status <= (q_len == '0) ? ST_EMPTY : ST_OK;
                end else begin
                    res_reg.status <= too_far ? ST_TOO_FAR : ST_OK;
                end
            end
            S_SEARCH: begin
                if (equal) begin
                    idx_reg <= mid_reg;
                end else if (greater) begin
                    lo_reg  <= lo_g;
                    mid_reg <= mid_g;
                end else begin
                    hip_reg <= mid_ext;
                    mid_reg <= mid_l;
                end
                if (!equal && !go_on) begin
                    idx_reg <= idx_end;
                end
            end
            S_DIVIDE: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - div_reg;
                end
                div_reg  <= div_reg >> 1;
                idx_reg  <= quo_new;
                step_reg <= step_reg - STEP_W'(1);
            end
            S_LATCH: begin
                res_reg.status       <= ST_OK;
                res_reg.row_position <= ROW_W'(ROW_W'(idx_reg) * ROW_W'(ROW_STRIDE));
                res_reg.found_value  <= ram_rdata;
                res_reg.is_outdated  <= od_reg;
            end
            default: begin
            end
        endcase
    end

    assign res_valid = (state_reg == S_REPLY);
    assign res       = res_reg;

endmodule

[rtl/sampled_rank_lookup_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_rank_lookup_core - sampled leaderboard position and page lookup
// Holds descending sampled arrays in one RAM and answers rank queries.
// ----------------------------------------------------------------------------
// Load requests may follow back to back; they give no result. A position
// query runs setup, P binary-search probes, latch and reply, with a fetch
// before latch when the search ends without an exact match. P is at most
// ceil(log2(length + 1)), so 13 for a full array of 4096 samples, with one
// probe a cycle on the sample RAM's single read port. A page query runs
// setup, a twelve-step restoring divide by the row stride, fetch, latch
// and reply. Unavailable, empty or too-far queries go from setup to reply.
// No request is taken until the query is back in idle. The sample RAM is
// not cleared: a query must never reach a slot below the array length that
// was never loaded. A result waits in the output register while the next
// request is already taken. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module sampled_rank_lookup_core
    import srl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  srl_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output srl_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [NUM_TABLES-1:0]  cfg_data
);

    srl_cfg_t           cfg_reg;
    srl_out_t           out_reg;
    logic               out_valid_reg;

    logic               eng_res_valid;
    logic               eng_res_ready;
    srl_out_t           eng_res;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // Configuration: accept a write every cycle, ignore unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_AVAILABLE_MASK: begin
                    cfg_reg.available_mask <= cfg_data;
                end
                REG_OUTDATED_MASK: begin
                    cfg_reg.outdated_mask <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Sample store: every array sits at its own block of ENTRIES_PER_ARRAY slots
    srl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_sample_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srl_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .cfg       (cfg_reg),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: take a new result when empty or being drained this cycle
    assign eng_res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (eng_res_valid && eng_res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_res_valid && eng_res_ready) begin
            out_reg <= eng_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A failed query carries nothing but its status
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |->
            (m_data.row_position == '0 && m_data.found_value == '0
             && !m_data.is_outdated))
        else $error("failed query result carries payload");

    // Reported row stays inside the sampled span
    a_row_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.row_position) < ENTRIES_PER_ARRAY * ROW_STRIDE))
        else $error("row position beyond array span");

    // No request is taken while the engine still holds an undelivered result
    a_hold_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_res_valid |-> !s_ready)
        else $error("request taken while result pending in engine");

    // Output is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule
